// ===== hdl/dsr_pkg.sv =====
// shared types and constants for the dedup site recorder
package dsr_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int BANK_W        = 8;
    localparam int ADDR_W        = 16;
    localparam int KEY_W         = BANK_W + ADDR_W;
    localparam int INDEX_W       = 6;
    localparam int COUNT_OUT_W   = 7;
    localparam int TOTAL_W       = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [BANK_W-1:0]   site_bank;
        logic [ADDR_W-1:0]   site_addr;
        logic [INDEX_W-1:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic                   was_duplicate;
        logic                   was_stored;
        logic [COUNT_OUT_W-1:0] stored_count;
        logic [TOTAL_W-1:0]     unique_total;
        logic [BANK_W-1:0]      entry_bank;
        logic [ADDR_W-1:0]      entry_addr;
        logic                   entry_valid;
    } t_result;

    // classified command handed from front to back
    typedef struct packed {
        logic               is_read;
        logic [KEY_W-1:0]   key;
        logic [INDEX_W-1:0] index;
    } t_cmd;

endpackage

// ===== hdl/dsr_front.sv =====
// front end: accepts and classifies commands into a two-entry queue
module dsr_front
    import dsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_pop
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       push;
    t_cmd       new_cmd;

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push        = i_start && !o_full;

    always_comb begin
        new_cmd.is_read = (i_item.operation == OP_READ);
        new_cmd.key     = {i_item.site_bank, i_item.site_addr};
        new_cmd.index   = i_item.read_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // payload slots, no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= new_cmd;
        end
    end

endmodule

// ===== hdl/dsr_back.sv =====
// back end: site table, sequential compare scan, counters and result register
module dsr_back
    import dsr_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_done,
    output t_result o_result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int HW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RDWAIT
    } t_state;

    logic [KEY_W-1:0] mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rd_data;

    t_state           r_state,  n_state;
    t_cmd             r_cmd,    n_cmd;
    logic [AW-1:0]    r_ptr,    n_ptr;
    logic [CW-1:0]    r_held,   n_held;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic             r_done,   n_done;
    t_result          r_result, n_result;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic             do_append;
    logic [KEY_W-1:0] app_key;
    logic [CW-1:0]    ptr_inc;
    logic [IW-1:0]    idx_w;
    logic [HW-1:0]    cur_count_x;
    logic [HW-1:0]    new_count_x;

    assign o_done   = r_done;
    assign o_result = r_result;
    assign ptr_inc  = CW'(r_ptr) + CW'(1);
    assign idx_w    = IW'(i_cmd.index);
    assign cur_count_x = HW'(r_held);
    assign new_count_x = HW'(n_held);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_ptr     = r_ptr;
        n_held    = r_held;
        n_total   = r_total;
        n_done    = 1'b0;
        n_result  = r_result;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        do_append = 1'b0;
        app_key   = r_cmd.key;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    if (i_cmd.is_read) begin
                        if (idx_w < IW'(r_held)) begin
                            rd_en   = 1'b1;
                            rd_addr = idx_w[AW-1:0];
                            n_state = S_RDWAIT;
                        end else begin
                            n_done   = 1'b1;
                            n_result = '0;
                            n_result.stored_count = cur_count_x[COUNT_OUT_W-1:0];
                            n_result.unique_total = r_total;
                        end
                    end else if (r_held == '0) begin
                        do_append = 1'b1;
                        app_key   = i_cmd.key;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_ptr   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_data == r_cmd.key) begin
                    n_done   = 1'b1;
                    n_result = '0;
                    n_result.was_duplicate = 1'b1;
                    n_result.stored_count  = cur_count_x[COUNT_OUT_W-1:0];
                    n_result.unique_total  = r_total;
                    n_state  = S_IDLE;
                end else if (ptr_inc == r_held) begin
                    do_append = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_inc[AW-1:0];
                    n_ptr   = ptr_inc[AW-1:0];
                end
            end
            S_RDWAIT: begin
                n_done   = 1'b1;
                n_result = '0;
                n_result.stored_count = cur_count_x[COUNT_OUT_W-1:0];
                n_result.unique_total = r_total;
                n_result.entry_bank   = r_rd_data[KEY_W-1:ADDR_W];
                n_result.entry_addr   = r_rd_data[ADDR_W-1:0];
                n_result.entry_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        wr_en = 1'b0;
        if (do_append) begin
            if (r_held < CW'(TABLE_DEPTH)) begin
                wr_en  = 1'b1;
                n_held = r_held + CW'(1);
            end
            if (r_total != '1) begin
                n_total = r_total + TOTAL_W'(1);
            end
            n_done   = 1'b1;
            n_result = '0;
            n_result.was_stored   = wr_en;
            n_result.stored_count = new_count_x[COUNT_OUT_W-1:0];
            n_result.unique_total = n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_total <= n_total;
            r_done  <= n_done;
        end
        r_cmd    <= n_cmd;
        r_ptr    <= n_ptr;
        r_result <= n_result;
    end

    // site table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_held[AW-1:0]] <= app_key;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/dedup_site_recorder_top.sv =====
// top level of the dedup site recorder
//
// command channel: present a command on i_item and raise start; the transfer
// happens at the rising edge where start is high and busy is low. busy is
// high only while the two-entry command queue is full, so up to two commands
// can wait while the back end works on a third.
// result channel: o_done is high for exactly one cycle with the result on
// o_result; the receiver cannot stall it, so it must take every result then.
// each command gives exactly one result, in command order.
// insert: the back end walks the stored entries with one comparator, one
// entry per cycle out of the table memory port, and stops at the first match.
// with an empty table the site is stored without a scan.
// read: a held index is read out of the table memory before the result;
// any other index gives its result without a table read.
// the back end finishes each command before it pops the next from the queue.
// reset (synchronous, active low) empties the queue, clears the stored count
// and the unique total; table contents are not cleared and are only read
// at indexes below the stored count.
module dedup_site_recorder_top
    import dsr_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_in_item i_item,
    output logic     o_done,
    output t_result  o_result
);

    // front to back handoff
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    dsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .o_full      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (cmd_pop)
    );

    dsr_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (cmd_pop),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    // an insert is either a duplicate or new, never both
    a_dup_xor_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.was_duplicate && o_result.was_stored))
        else $error("insert flagged both duplicate and stored");

    // a read result for a held entry never carries insert flags
    a_read_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.entry_valid) |->
            (!o_result.was_duplicate && !o_result.was_stored))
        else $error("read result carries insert flags");

    // a stored site has always been counted
    a_stored_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.was_stored) |-> (o_result.unique_total != '0))
        else $error("stored site not counted");

    // no result strobe right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

endmodule

// ===== tb/dedup_site_recorder_top_test.sv =====
// self-checking testbench for the dedup site recorder top level
`timescale 1ns / 1ps

module dedup_site_recorder_top_test;
    import dsr_pkg::*;

    localparam int TABLE_DEPTH  = DEPTH_DEFAULT;
    // the slowest insert scans the whole table, plus room for two queued
    // commands ahead of it and a sender gap, taken many times over
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1280;
    // last stretch of the random part runs with no sender gaps
    localparam int QUIET_FROM   = 1100;

    // one row of the directed table: the command, and the outcome when it is
    // obvious enough to write down by hand
    typedef struct packed {
        t_in_item stim;
        logic     typed;
        t_result  outcome;
    } t_dir_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_in_item i_item  = '0;
    logic     busy;
    logic     o_done;
    t_result  o_result;

    // own copy of the site table, the held count and the unique total
    logic [KEY_W-1:0]   site_mem [TABLE_DEPTH];
    int                 held_sites   = 0;
    logic [TOTAL_W-1:0] unique_sites = '0;

    // outcomes of accepted commands, oldest first
    t_result            awaited_outcomes [$];
    // every key ever inserted, stored or not, used to draw repeats
    logic [KEY_W-1:0]   inserted_keys [$];
    t_dir_row           directed_rows [$];

    int mismatch_count = 0;
    int stall_cycles   = 0;

    dedup_site_recorder_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_in_item cmd(input logic op, input logic [BANK_W-1:0] bank,
                                     input logic [ADDR_W-1:0] addr,
                                     input logic [INDEX_W-1:0] idx);
        t_in_item it;
        it.operation  = op;
        it.site_bank  = bank;
        it.site_addr  = addr;
        it.read_index = idx;
        return it;
    endfunction

    function automatic t_result res(input logic dup, input logic stored,
                                    input logic [COUNT_OUT_W-1:0] cnt,
                                    input logic [TOTAL_W-1:0] total,
                                    input logic [BANK_W-1:0] ebank,
                                    input logic [ADDR_W-1:0] eaddr,
                                    input logic evalid);
        t_result r;
        r.was_duplicate = dup;
        r.was_stored    = stored;
        r.stored_count  = cnt;
        r.unique_total  = total;
        r.entry_bank    = ebank;
        r.entry_addr    = eaddr;
        r.entry_valid   = evalid;
        return r;
    endfunction

    // apply one command to the local table and return what the block must answer
    function automatic t_result record_site(input t_in_item it);
        t_result          r;
        logic [KEY_W-1:0] key;
        logic             hit;
        r   = '0;
        key = {it.site_bank, it.site_addr};
        hit = 1'b0;
        if (it.operation == OP_INSERT) begin
            for (int i = 0; i < held_sites; i++) begin
                if (site_mem[i] == key) hit = 1'b1;
            end
            if (hit) begin
                r.was_duplicate = 1'b1;
            end else begin
                // a full table still counts the site, it just is not kept
                if (held_sites < TABLE_DEPTH) begin
                    site_mem[held_sites] = key;
                    held_sites++;
                    r.was_stored = 1'b1;
                end
                if (unique_sites != '1) unique_sites++;
            end
        end else if (int'(it.read_index) < held_sites) begin
            r.entry_valid = 1'b1;
            r.entry_bank  = site_mem[it.read_index][KEY_W-1:ADDR_W];
            r.entry_addr  = site_mem[it.read_index][ADDR_W-1:0];
        end
        r.stored_count = COUNT_OUT_W'(held_sites);
        r.unique_total = unique_sites;
        return r;
    endfunction

    // present one command, hold it until the transfer, then log its outcome
    task automatic send_item(input t_in_item it, input bit may_idle, input bit typed,
                             input t_result typed_outcome);
        t_result predicted;
        @(negedge i_clk);
        if (may_idle && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = record_site(it);
        if (it.operation == OP_INSERT) inserted_keys.push_back({it.site_bank, it.site_addr});
        awaited_outcomes.push_back(typed ? typed_outcome : predicted);
    endtask

    // sender goes quiet until every outstanding result has come back
    task automatic hold_until_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // result side: every strobe must match the oldest outstanding outcome
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (awaited_outcomes.size() == 0) begin
                $error("result with no command outstanding: %0h", o_result);
                mismatch_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                check_field("was_duplicate", TOTAL_W'(want.was_duplicate),
                            TOTAL_W'(o_result.was_duplicate));
                check_field("was_stored", TOTAL_W'(want.was_stored),
                            TOTAL_W'(o_result.was_stored));
                check_field("stored_count", TOTAL_W'(want.stored_count),
                            TOTAL_W'(o_result.stored_count));
                check_field("unique_total", want.unique_total, o_result.unique_total);
                check_field("entry_bank", TOTAL_W'(want.entry_bank),
                            TOTAL_W'(o_result.entry_bank));
                check_field("entry_addr", TOTAL_W'(want.entry_addr),
                            TOTAL_W'(o_result.entry_addr));
                check_field("entry_valid", TOTAL_W'(want.entry_valid),
                            TOTAL_W'(o_result.entry_valid));
            end
        end
    end

    // watchdog: too long with neither a command nor a result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        t_in_item it;
        int       pick;
        bit       fresh;

        // directed part: empty table, extreme keys, duplicates, reads in and
        // out of range, and a read whose unused site fields carry junk
        directed_rows.push_back('{cmd(OP_READ, 8'h00, 16'h0000, 6'd0), 1'b1,
                                  res(1'b0, 1'b0, 7'd0, 32'd0, 8'h00, 16'h0000, 1'b0)});
        directed_rows.push_back('{cmd(OP_READ, 8'hFF, 16'hFFFF, 6'd63), 1'b1,
                                  res(1'b0, 1'b0, 7'd0, 32'd0, 8'h00, 16'h0000, 1'b0)});
        directed_rows.push_back('{cmd(OP_INSERT, 8'h00, 16'h0000, 6'd63), 1'b1,
                                  res(1'b0, 1'b1, 7'd1, 32'd1, 8'h00, 16'h0000, 1'b0)});
        directed_rows.push_back('{cmd(OP_INSERT, 8'h00, 16'h0000, 6'd0), 1'b1,
                                  res(1'b1, 1'b0, 7'd1, 32'd1, 8'h00, 16'h0000, 1'b0)});
        directed_rows.push_back('{cmd(OP_INSERT, 8'hFF, 16'hFFFF, 6'd0), 1'b1,
                                  res(1'b0, 1'b1, 7'd2, 32'd2, 8'h00, 16'h0000, 1'b0)});
        directed_rows.push_back('{cmd(OP_READ, 8'h00, 16'h0000, 6'd0), 1'b1,
                                  res(1'b0, 1'b0, 7'd2, 32'd2, 8'h00, 16'h0000, 1'b1)});
        directed_rows.push_back('{cmd(OP_READ, 8'h5A, 16'h1234, 6'd1), 1'b1,
                                  res(1'b0, 1'b0, 7'd2, 32'd2, 8'hFF, 16'hFFFF, 1'b1)});
        directed_rows.push_back('{cmd(OP_READ, 8'h00, 16'h0000, 6'd2), 1'b1,
                                  res(1'b0, 1'b0, 7'd2, 32'd2, 8'h00, 16'h0000, 1'b0)});
        directed_rows.push_back('{cmd(OP_INSERT, 8'hFF, 16'hFFFF, 6'd21), 1'b1,
                                  res(1'b1, 1'b0, 7'd2, 32'd2, 8'h00, 16'h0000, 1'b0)});
        // same address or same bank alone is a different site
        directed_rows.push_back('{cmd(OP_INSERT, 8'h00, 16'hFFFF, 6'd42), 1'b1,
                                  res(1'b0, 1'b1, 7'd3, 32'd3, 8'h00, 16'h0000, 1'b0)});
        directed_rows.push_back('{cmd(OP_INSERT, 8'hFF, 16'h0000, 6'd0), 1'b1,
                                  res(1'b0, 1'b1, 7'd4, 32'd4, 8'h00, 16'h0000, 1'b0)});
        directed_rows.push_back('{cmd(OP_INSERT, 8'h00, 16'hFFFF, 6'd63), 1'b1,
                                  res(1'b1, 1'b0, 7'd4, 32'd4, 8'h00, 16'h0000, 1'b0)});
        directed_rows.push_back('{cmd(OP_READ, 8'hFF, 16'hFFFF, 6'd63), 1'b1,
                                  res(1'b0, 1'b0, 7'd4, 32'd4, 8'h00, 16'h0000, 1'b0)});
        directed_rows.push_back('{cmd(OP_READ, 8'hA5, 16'h5A5A, 6'd3), 1'b0, '0});
        directed_rows.push_back('{cmd(OP_INSERT, 8'hA5, 16'h5A5A, 6'd10), 1'b0, '0});
        directed_rows.push_back('{cmd(OP_INSERT, 8'h5A, 16'hA5A5, 6'd53), 1'b0, '0});
        directed_rows.push_back('{cmd(OP_INSERT, 8'hA5, 16'h5A5A, 6'd5), 1'b0, '0});
        directed_rows.push_back('{cmd(OP_READ, 8'h00, 16'h0000, 6'd5), 1'b0, '0});
        directed_rows.push_back('{cmd(OP_READ, 8'h00, 16'h0000, 6'd4), 1'b0, '0});

        // synchronous reset, applied once
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].stim, 1'b1, directed_rows[r].typed,
                      directed_rows[r].outcome);
        end
        hold_until_drained();

        // random part: early on mostly repeats and reads so the table fills
        // slowly, later many new sites so the table runs full and keeps
        // counting sites it can no longer store; the unique total cannot
        // reach saturation in a run of this length
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            it.operation  = ($urandom_range(0, 9) < 4) ? OP_READ : OP_INSERT;
            it.site_bank  = ($urandom_range(0, 7) == 0) ? 8'hFF : BANK_W'($urandom_range(0, 255));
            it.site_addr  = ($urandom_range(0, 7) == 0) ? 16'h0000 :
                            ADDR_W'($urandom_range(0, 65535));
            it.read_index = INDEX_W'($urandom_range(0, 63));
            if (it.operation == OP_READ) begin
                // mostly indexes that are held, the rest anywhere
                if (held_sites > 0 && $urandom_range(0, 3) != 0)
                    it.read_index = INDEX_W'($urandom_range(0, held_sites - 1));
            end else begin
                fresh = (n < 600) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 1) == 0);
                if (!fresh && inserted_keys.size() > 0) begin
                    pick = $urandom_range(0, inserted_keys.size() - 1);
                    {it.site_bank, it.site_addr} = inserted_keys[pick];
                end
            end
            send_item(it, n < QUIET_FROM, 1'b0, '0);
            if (n == 400 || n == 800) hold_until_drained();
        end

        // let the last results come back, then a scan's worth of quiet
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dsr_pkg.sv
hdl/dsr_front.sv
hdl/dsr_back.sv
hdl/dedup_site_recorder_top.sv
tb/dedup_site_recorder_top_test.sv
